// File: rtl/isqdd_pkg.sv
package isqdd_pkg;

	// width of the radicand and root fields on the ports
	localparam int unsigned RADICAND_W = 32;
	localparam int unsigned ROOT_W     = 17;

	// largest root the block can show: a rounded root of a radicand near 2^32
	localparam logic [ROOT_W-1:0] ROOT_MAX = ROOT_W'(17'h10000);

endpackage

// File: rtl/isqdd_cell.sv
// One digit step of the restoring square root: trial subtract root + bit
// from the remainder, keep the result bit, shift the root down by one.
module isqdd_cell #(
	parameter int unsigned W     = 32,
	parameter int unsigned SHIFT = 30
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         up_valid,
	output logic         up_ready,
	input  logic [W-1:0] up_rem,
	input  logic [W:0]   up_root,
	input  logic         up_rnd,
	output logic         dn_valid,
	input  logic         dn_ready,
	output logic [W-1:0] dn_rem,
	output logic [W:0]   dn_root,
	output logic         dn_rnd
);

	localparam logic [W:0] BIT  = (W+1)'(1) << SHIFT;
	localparam logic [W:0] BIT2 = BIT << 1;

	logic         valid_q;
	logic [W-1:0] rem_q;
	logic [W:0]   root_q;
	logic         rnd_q;

	logic [W:0]   trial;
	logic         take;
	logic [W-1:0] rem_n;
	logic [W:0]   root_sum;

	assign trial    = up_root + BIT;
	assign take     = {1'b0, up_rem} >= trial;
	assign rem_n    = take ? (up_rem - trial[W-1:0]) : up_rem;
	assign root_sum = take ? (up_root + BIT2) : up_root;

	// a cell frees up when it is empty or its word moves on this cycle
	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			rem_q  <= rem_n;
			root_q <= root_sum >> 1;
			rnd_q  <= up_rnd;
		end
	end

	assign dn_valid = valid_q;
	assign dn_rem   = rem_q;
	assign dn_root  = root_q;
	assign dn_rnd   = rnd_q;

endmodule

// File: rtl/integer_sqrt_digit_by_digit_top.sv
// Integer square root, restoring digit-by-digit method, one digit per cell.
//
// Input channel: in_valid / in_stall carry one word of radicand (32 bits,
// unsigned; only the low INPUT_WIDTH bits count) and round_to_nearest.
// Output channel: out_valid / out_stall carry one word of root (17 bits).
// A word moves at a rising edge with valid high and stall low.
//
// The root comes out of a chain of (INPUT_WIDTH-1)/2+1 identical cells,
// sixteen for the default width, followed by one output register that
// applies rounding. One word enters every cycle while the output is not
// stalled; throughput is then one word per cycle.
//
// When the receiver stalls, the output register holds its word and each
// cell holds its word only if the cell after it is full, so empty slots
// in the chain close up and input keeps flowing until the chain is full.
// Reset clears every valid flag; payload registers are not reset.
module integer_sqrt_digit_by_digit_top
	import isqdd_pkg::*;
#(
	parameter int unsigned INPUT_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [RADICAND_W-1:0] radicand,
	input  logic                  round_to_nearest,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [ROOT_W-1:0]     root
);

	localparam int unsigned W     = INPUT_WIDTH;
	localparam int unsigned TOP   = ((W - 1) / 2) * 2;
	localparam int unsigned NSTEP = TOP / 2 + 1;

	// link k feeds cell k; link NSTEP feeds the output register
	logic         lk_valid [NSTEP+1];
	logic         lk_ready [NSTEP+1];
	logic [W-1:0] lk_rem   [NSTEP+1];
	logic [W:0]   lk_root  [NSTEP+1];
	logic         lk_rnd   [NSTEP+1];

	logic                out_valid_q;
	logic [ROOT_W-1:0]   root_q;
	logic                out_ready;
	logic [W:0]          root_fin;

	// drop radicand bits above INPUT_WIDTH, or zero-extend when wider
	assign lk_valid[0] = in_valid;
	assign lk_rem[0]   = W'(radicand);
	assign lk_root[0]  = '0;
	assign lk_rnd[0]   = round_to_nearest;
	assign in_stall    = !lk_ready[0];

	for (genvar k = 0; k < NSTEP; k++) begin : g_cell
		isqdd_cell #(
			.W     (W),
			.SHIFT (TOP - 2 * k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (lk_valid[k]),
			.up_ready (lk_ready[k]),
			.up_rem   (lk_rem[k]),
			.up_root  (lk_root[k]),
			.up_rnd   (lk_rnd[k]),
			.dn_valid (lk_valid[k+1]),
			.dn_ready (lk_ready[k+1]),
			.dn_rem   (lk_rem[k+1]),
			.dn_root  (lk_root[k+1]),
			.dn_rnd   (lk_rnd[k+1])
		);
	end

	// output register: with round_to_nearest set, round up when the final remainder exceeds the root
	assign out_ready          = !out_valid_q || !out_stall;
	assign lk_ready[NSTEP]    = out_ready;
	assign root_fin = lk_root[NSTEP] +
		(W+1)'(lk_rnd[NSTEP] && ({1'b0, lk_rem[NSTEP]} > lk_root[NSTEP]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= lk_valid[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && lk_valid[NSTEP]) begin
			root_q <= ROOT_W'(root_fin);
		end
	end

	assign out_valid = out_valid_q;
	assign root      = root_q;

endmodule

// File: rtl/isqdd_checker.sv
module isqdd_checker
	import isqdd_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [RADICAND_W-1:0] radicand,
	input logic                  round_to_nearest,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [ROOT_W-1:0]     root
);

	// a held result word stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(root))
		else $error("result word changed while stalled");

	// with the output free to move the chain always has room for a word
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |-> !in_stall)
		else $error("input stalled while output side can drain");

	// the root of a 32-bit radicand never passes 2^16
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> root <= ROOT_MAX)
		else $error("root out of range");

	// an offered input word stays put until the block takes it
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=>
			in_valid && $stable(radicand) && $stable(round_to_nearest))
		else $error("input word changed while stalled");

endmodule

bind integer_sqrt_digit_by_digit_top isqdd_checker u_isqdd_checker (.*);
